// ----- rtl/cylindrical_gravity_half_kick_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cylindrical gravity half kick
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CYLINDRICAL_GRAVITY_HALF_KICK_ASSERT_SVH
`define CYLINDRICAL_GRAVITY_HALF_KICK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CGHK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CGHK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CGHK_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cghk_pkg.sv -----
// ----------------------------------------------------------------------------
// cghk_pkg
// Shared constants, types and CORDIC angle table for the half kick pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cghk_pkg;

  localparam int unsigned AtanEntries       = 24;
  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned ValW              = 32;
  localparam int unsigned AzimuthW          = 16;
  localparam int unsigned AngleW            = 32;
  localparam int unsigned XyW               = 34;
  localparam int unsigned RegIdxW           = 2;

  // 0.6072529350 in Q4.30
  localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  localparam logic [AngleW-1:0] AtanTurn [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [RegIdxW-1:0] {
    REG_GRAVITY_X = 2'd0,
    REG_GRAVITY_Y = 2'd1,
    REG_GRAVITY_Z = 2'd2,
    REG_TIME_STEP = 2'd3
  } cghk_reg_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } cghk_quad_e;

  typedef struct packed {
    logic signed [ValW-1:0] gravity_x;
    logic signed [ValW-1:0] gravity_y;
    logic signed [ValW-1:0] gravity_z;
    logic [ValW-1:0]        time_step;
  } cghk_cfg_t;

  typedef struct packed {
    logic signed [ValW-1:0] vel_radial;
    logic signed [ValW-1:0] vel_vertical;
    logic signed [ValW-1:0] vel_azimuthal;
    logic                   batch_end;
  } cghk_carry_t;

  typedef struct packed {
    logic signed [XyW-1:0]    x;
    logic signed [XyW-1:0]    y;
    logic signed [AngleW-1:0] z;
    cghk_quad_e               quad;
  } cghk_rot_t;

  typedef struct packed {
    logic signed [ValW-1:0] new_radial;
    logic signed [ValW-1:0] new_vertical;
    logic signed [ValW-1:0] new_azimuthal;
    logic                   saturated;
    logic                   batch_last;
  } cghk_result_t;

endpackage

// ----- rtl/cghk_stream_if.sv -----
// ----------------------------------------------------------------------------
// cghk stream interfaces
// Valid/ready channels for particle input and updated velocity output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cghk_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        azimuth;
  logic signed [31:0] vel_radial;
  logic signed [31:0] vel_vertical;
  logic signed [31:0] vel_azimuthal;
  logic               batch_end;

  modport source (
    output valid, azimuth, vel_radial, vel_vertical, vel_azimuthal, batch_end,
    input  ready
  );
  modport sink (
    input  valid, azimuth, vel_radial, vel_vertical, vel_azimuthal, batch_end,
    output ready
  );
endinterface

interface cghk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_radial;
  logic signed [31:0] new_vertical;
  logic signed [31:0] new_azimuthal;
  logic               saturated;
  logic               batch_last;

  modport source (
    output valid, new_radial, new_vertical, new_azimuthal, saturated, batch_last,
    input  ready
  );
  modport sink (
    input  valid, new_radial, new_vertical, new_azimuthal, saturated, batch_last,
    output ready
  );
endinterface

// ----- rtl/cghk_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// cghk_cordic_cell
// One registered CORDIC rotation step; carries the particle payload along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cghk_cordic_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cghk_pkg::cghk_rot_t   rot_i,
  input  cghk_pkg::cghk_carry_t carry_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cghk_pkg::cghk_rot_t   rot_o,
  output cghk_pkg::cghk_carry_t carry_o
);
  import cghk_pkg::*;

  localparam logic signed [AngleW-1:0] Atan = signed'(AtanTurn[Shift]);

  logic        valid_q;
  cghk_rot_t   rot_d, rot_q;
  cghk_carry_t carry_q;
  logic signed [XyW-1:0] dx, dy;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx    = rot_i.y >>> Shift;
    dy    = rot_i.x >>> Shift;
    rot_d = rot_i;
    // rotate toward zero residual angle
    if (!rot_i.z[AngleW-1]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - Atan;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rot_q   <= rot_d;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign carry_o = carry_q;

endmodule

// ----- rtl/cghk_rotate.sv -----
// ----------------------------------------------------------------------------
// cghk_rotate
// Restores the quadrant and rotates Cartesian gravity into radial and
// azimuthal parts, rounded to Q16.16. Three registered stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cghk_rotate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  cghk_pkg::cghk_rot_t                    rot_i,
  input  cghk_pkg::cghk_carry_t                  carry_i,
  input  cghk_pkg::cghk_cfg_t                    cfg_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [cghk_pkg::XyW-1:0]       grav_radial_o,
  output logic signed [cghk_pkg::XyW-1:0]       grav_azimuthal_o,
  output cghk_pkg::cghk_carry_t                  carry_o
);
  import cghk_pkg::*;

  localparam int unsigned Stages = 3;
  localparam int unsigned ProdW  = ValW + XyW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned Frac   = 30;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(64'sd536870912);

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] stage_ready;
  cghk_carry_t       carry_q [Stages];

  logic signed [XyW-1:0]   cos_d, sin_d, cos_q, sin_q;
  logic signed [ProdW-1:0] xc_q, ys_q, yc_q, xs_q;
  logic signed [SumW-1:0]  sum_r, sum_phi;
  logic signed [XyW-1:0]   gr_q, gphi_q;

  assign stage_ready[2] = !valid_q[2] || ready_i;
  assign stage_ready[1] = !valid_q[1] || stage_ready[2];
  assign stage_ready[0] = !valid_q[0] || stage_ready[1];
  assign ready_o        = stage_ready[0];

  always_comb begin
    unique case (rot_i.quad)
      QUAD_0: begin
        cos_d = rot_i.x;
        sin_d = rot_i.y;
      end
      QUAD_90: begin
        cos_d = -rot_i.y;
        sin_d = rot_i.x;
      end
      QUAD_180: begin
        cos_d = -rot_i.x;
        sin_d = -rot_i.y;
      end
      QUAD_270: begin
        cos_d = rot_i.y;
        sin_d = -rot_i.x;
      end
      default: begin
        cos_d = rot_i.x;
        sin_d = rot_i.y;
      end
    endcase
  end

  assign sum_r   = SumW'(xc_q) + SumW'(ys_q) + RoundHalf;
  assign sum_phi = SumW'(yc_q) - SumW'(xs_q) + RoundHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_ready[0]) valid_q[0] <= valid_i;
      if (stage_ready[1]) valid_q[1] <= valid_q[0];
      if (stage_ready[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[0]) begin
      cos_q      <= cos_d;
      sin_q      <= sin_d;
      carry_q[0] <= carry_i;
    end
    if (stage_ready[1]) begin
      xc_q       <= ProdW'(cfg_i.gravity_x) * ProdW'(cos_q);
      ys_q       <= ProdW'(cfg_i.gravity_y) * ProdW'(sin_q);
      yc_q       <= ProdW'(cfg_i.gravity_y) * ProdW'(cos_q);
      xs_q       <= ProdW'(cfg_i.gravity_x) * ProdW'(sin_q);
      carry_q[1] <= carry_q[0];
    end
    if (stage_ready[2]) begin
      // floor of (sum + half) / 2^30; the result fits in XyW bits
      gr_q       <= sum_r[Frac +: XyW];
      gphi_q     <= sum_phi[Frac +: XyW];
      carry_q[2] <= carry_q[1];
    end
  end

  assign valid_o          = valid_q[2];
  assign grav_radial_o    = gr_q;
  assign grav_azimuthal_o = gphi_q;
  assign carry_o          = carry_q[2];

endmodule

// ----- rtl/cghk_kick.sv -----
// ----------------------------------------------------------------------------
// cghk_kick
// Scales each gravity part by half the time step, rounds, adds it to the
// velocity and saturates. Three registered stages, the last is the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cghk_kick (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic signed [cghk_pkg::XyW-1:0] grav_radial_i,
  input  logic signed [cghk_pkg::XyW-1:0] grav_azimuthal_i,
  input  cghk_pkg::cghk_carry_t            carry_i,
  input  cghk_pkg::cghk_cfg_t              cfg_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output cghk_pkg::cghk_result_t           result_o
);
  import cghk_pkg::*;

  localparam int unsigned Stages = 3;
  localparam int unsigned Comps  = 3;
  localparam int unsigned ProdW  = 2 * ValW;
  localparam int unsigned RndW   = ProdW + 1;
  localparam int unsigned KickW  = ValW - 1;
  localparam int unsigned SumW   = ValW + 2;
  localparam logic [RndW-1:0] RoundHalf = RndW'(1) << ValW;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] stage_ready;
  cghk_carry_t       carry_q [Stages-1];

  logic signed [XyW-1:0]  grav [Comps];
  logic signed [XyW-1:0]  grav_abs [Comps];
  logic [ValW-1:0]        mag_q [Comps];
  logic                   neg_q [Comps];
  logic                   neg1_q [Comps];
  logic [ProdW-1:0]       prod_q [Comps];
  logic [RndW-1:0]        rnd [Comps];
  logic signed [SumW-1:0] kick [Comps];
  logic signed [SumW-1:0] total [Comps];
  logic signed [ValW-1:0] vel [Comps];
  logic signed [ValW-1:0] clip [Comps];
  logic [Comps-1:0]       over;
  cghk_result_t           result_d, result_q;

  assign stage_ready[2] = !valid_q[2] || ready_i;
  assign stage_ready[1] = !valid_q[1] || stage_ready[2];
  assign stage_ready[0] = !valid_q[0] || stage_ready[1];
  assign ready_o        = stage_ready[0];

  assign grav[0] = grav_radial_i;
  assign grav[1] = XyW'(cfg_i.gravity_z);
  assign grav[2] = grav_azimuthal_i;

  assign vel[0] = carry_q[1].vel_radial;
  assign vel[1] = carry_q[1].vel_vertical;
  assign vel[2] = carry_q[1].vel_azimuthal;

  always_comb begin
    for (int k = 0; k < Comps; k++) begin
      grav_abs[k] = grav[k][XyW-1] ? -grav[k] : grav[k];
      // half of the product, rounded to nearest with ties away from zero
      rnd[k]      = RndW'(prod_q[k]) + RoundHalf;
      kick[k]     = SumW'({1'b0, rnd[k][ValW+1 +: KickW]});
      if (neg1_q[k]) begin
        kick[k] = -kick[k];
      end
      total[k]    = SumW'(vel[k]) + kick[k];
      over[k]     = (total[k][SumW-1:ValW-1] != {(SumW-ValW+1){total[k][SumW-1]}});
      if (!over[k]) begin
        clip[k] = total[k][ValW-1:0];
      end else if (total[k][SumW-1]) begin
        clip[k] = {1'b1, {(ValW-1){1'b0}}};
      end else begin
        clip[k] = {1'b0, {(ValW-1){1'b1}}};
      end
    end
    result_d.new_radial    = clip[0];
    result_d.new_vertical  = clip[1];
    result_d.new_azimuthal = clip[2];
    result_d.saturated     = |over;
    result_d.batch_last    = carry_q[1].batch_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_ready[0]) valid_q[0] <= valid_i;
      if (stage_ready[1]) valid_q[1] <= valid_q[0];
      if (stage_ready[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[0]) begin
      for (int k = 0; k < Comps; k++) begin
        mag_q[k] <= grav_abs[k][ValW-1:0];
        neg_q[k] <= grav[k][XyW-1];
      end
      carry_q[0] <= carry_i;
    end
    if (stage_ready[1]) begin
      for (int k = 0; k < Comps; k++) begin
        prod_q[k] <= ProdW'(mag_q[k]) * ProdW'(cfg_i.time_step);
        neg1_q[k] <= neg_q[k];
      end
      carry_q[1] <= carry_q[0];
    end
    if (stage_ready[2]) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q[2];
  assign result_o = result_q;

endmodule

// ----- rtl/cylindrical_gravity_half_kick.sv -----
// Throughput: one particle per cycle while the output is ready; every stage is
// a registered cell in one chain. Each stage holds while the next is full,
// so bubbles collapse and input keeps flowing.
// Reset: async active low; clears all valid bits and the gravity/time step registers.
// ----------------------------------------------------------------------------
// cylindrical_gravity_half_kick
// Leapfrog half kick of cylindrical particle velocities under Cartesian gravity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cylindrical_gravity_half_kick #(
  parameter int unsigned CordicIterations = cghk_pkg::CordicIterDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cghk_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [cghk_pkg::ValW-1:0]      cfg_data_i,
  cghk_in_if.sink                        in_i,
  cghk_out_if.source                     out_o
);
  import cghk_pkg::*;

  localparam int unsigned NumCells =
      (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;

  cghk_cfg_t cfg_q;

  // input preparation stage
  logic        valid_p_q;
  logic        ready_p;
  cghk_rot_t   rot_p_d, rot_p_q;
  cghk_carry_t carry_p_d, carry_p_q;
  logic [AngleW-1:0] angle, angle_bias;

  logic [NumCells:0] cell_valid;
  logic [NumCells:0] cell_ready;
  cghk_rot_t         rot_chain [NumCells+1];
  cghk_carry_t       carry_chain [NumCells+1];

  logic                  rot_valid, rot_ready;
  logic signed [XyW-1:0] grav_radial, grav_azimuthal;
  cghk_carry_t           rot_carry;
  cghk_result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cghk_reg_e'(cfg_index_i))
        REG_GRAVITY_X: cfg_q.gravity_x <= cfg_data_i;
        REG_GRAVITY_Y: cfg_q.gravity_y <= cfg_data_i;
        REG_GRAVITY_Z: cfg_q.gravity_z <= cfg_data_i;
        REG_TIME_STEP: cfg_q.time_step <= cfg_data_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // split off the nearest quarter turn; residue lands in [-1/8, 1/8) turn
  always_comb begin
    angle      = {in_i.azimuth, {(AngleW-AzimuthW){1'b0}}};
    angle_bias = angle + (AngleW'(1) << (AngleW - 3));
    rot_p_d.quad = cghk_quad_e'(angle_bias[AngleW-1 -: 2]);
    rot_p_d.z    = angle - {angle_bias[AngleW-1 -: 2], {(AngleW-2){1'b0}}};
    rot_p_d.x    = CordicGain;
    rot_p_d.y    = '0;
    carry_p_d.vel_radial    = in_i.vel_radial;
    carry_p_d.vel_vertical  = in_i.vel_vertical;
    carry_p_d.vel_azimuthal = in_i.vel_azimuthal;
    carry_p_d.batch_end     = in_i.batch_end;
  end

  assign ready_p    = !valid_p_q || cell_ready[0];
  assign in_i.ready = ready_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
    end else if (ready_p) begin
      valid_p_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_p) begin
      rot_p_q   <= rot_p_d;
      carry_p_q <= carry_p_d;
    end
  end

  assign cell_valid[0]  = valid_p_q;
  assign rot_chain[0]   = rot_p_q;
  assign carry_chain[0] = carry_p_q;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cghk_cordic_cell #(
      .Shift(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[i]),
      .ready_o (cell_ready[i]),
      .rot_i   (rot_chain[i]),
      .carry_i (carry_chain[i]),
      .valid_o (cell_valid[i+1]),
      .ready_i (cell_ready[i+1]),
      .rot_o   (rot_chain[i+1]),
      .carry_o (carry_chain[i+1])
    );
  end

  cghk_rotate u_rotate (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (cell_valid[NumCells]),
    .ready_o          (cell_ready[NumCells]),
    .rot_i            (rot_chain[NumCells]),
    .carry_i          (carry_chain[NumCells]),
    .cfg_i            (cfg_q),
    .valid_o          (rot_valid),
    .ready_i          (rot_ready),
    .grav_radial_o    (grav_radial),
    .grav_azimuthal_o (grav_azimuthal),
    .carry_o          (rot_carry)
  );

  cghk_kick u_kick (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (rot_valid),
    .ready_o          (rot_ready),
    .grav_radial_i    (grav_radial),
    .grav_azimuthal_i (grav_azimuthal),
    .carry_i          (rot_carry),
    .cfg_i            (cfg_q),
    .valid_o          (out_o.valid),
    .ready_i          (out_o.ready),
    .result_o         (result)
  );

  assign out_o.new_radial    = result.new_radial;
  assign out_o.new_vertical  = result.new_vertical;
  assign out_o.new_azimuthal = result.new_azimuthal;
  assign out_o.saturated     = result.saturated;
  assign out_o.batch_last    = result.batch_last;

endmodule

// ----- rtl/cghk_checker.sv -----
// ----------------------------------------------------------------------------
// cghk_checker
// Port-level checks on the result channel of the half kick block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cylindrical_gravity_half_kick_assert.svh"

module cghk_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] new_radial_i,
  input logic signed [31:0] new_vertical_i,
  input logic signed [31:0] new_azimuthal_i,
  input logic               saturated_i,
  input logic               batch_last_i
);
  localparam logic signed [31:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;

  logic stalled;
  logic any_clipped;

  assign stalled     = out_valid_i && !out_ready_i;
  assign any_clipped = new_radial_i == ValMax || new_radial_i == ValMin ||
                       new_vertical_i == ValMax || new_vertical_i == ValMin ||
                       new_azimuthal_i == ValMax || new_azimuthal_i == ValMin;

  // hold a stalled transaction
  `CGHK_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, stalled, out_valid_i, "result dropped while stalled")
  `CGHK_ASSERT_NEXT(a_payload_hold, clk_i, rst_ni, stalled, $stable(new_radial_i) && $stable(new_vertical_i) && $stable(new_azimuthal_i) && $stable(saturated_i) && $stable(batch_last_i), "result changed while stalled")
  // a clipped result carries at least one rail value
  `CGHK_ASSERT_NOW(a_sat_rail, clk_i, rst_ni, out_valid_i && saturated_i, any_clipped, "saturated without a clipped component")
  // pipeline is empty right after reset
  `CGHK_ASSERT_ALWAYS_NEXT(a_reset_empty, clk_i, !rst_ni, !out_valid_i, "result valid right after reset")

endmodule

bind cylindrical_gravity_half_kick cghk_checker u_cghk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .new_radial_i    (out_o.new_radial),
  .new_vertical_i  (out_o.new_vertical),
  .new_azimuthal_i (out_o.new_azimuthal),
  .saturated_i     (out_o.saturated),
  .batch_last_i    (out_o.batch_last)
);
